### rtl/sst_pkg.sv
`default_nettype none
package sst_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    localparam int CHAR_W  = 8;
    localparam int TOTAL_W = 5;

    typedef struct packed {
        logic step;
        logic first;
        logic exec_ins;
        logic exec_del;
    } sst_ctl_t;

endpackage
`default_nettype wire

### rtl/sst_cell.sv
`default_nettype none
module sst_cell
    import sst_pkg::*;
#(
    parameter int WORD_CHARS = 16,
    parameter int KPW        = 5,
    parameter int CNTW       = 5,
    parameter int IDX        = 0
) (
    input  wire logic                                 clk,
    input  wire sst_ctl_t                             ctl,
    input  wire logic [CHAR_W-1:0]                    key_char,
    input  wire logic [KPW-1:0]                       kpos,
    input  wire logic [WORD_CHARS-1:0][CHAR_W-1:0]    key_buf,
    input  wire logic [CNTW-1:0]                      count,
    input  wire logic [WORD_CHARS-1:0][CHAR_W-1:0]    nb_chars,
    input  wire logic [KPW-1:0]                       nb_len,
    input  wire logic                                 shift_in,
    output logic      [WORD_CHARS-1:0][CHAR_W-1:0]    chars,
    output logic      [KPW-1:0]                       len,
    output logic                                      hit,
    output logic                                      shift_out
);

    localparam int KIW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;

    logic [WORD_CHARS-1:0][CHAR_W-1:0] chars_reg;
    logic [KPW-1:0]                    len_reg;
    logic                              match_reg;
    logic                              match_next;
    logic                              in_range;
    logic                              occupied;

    assign in_range  = (kpos < KPW'(WORD_CHARS));
    assign occupied  = (CNTW'(IDX) < count);
    assign hit       = match_reg && (len_reg == kpos) && occupied;
    assign shift_out = shift_in || hit;
    assign chars     = chars_reg;
    assign len       = len_reg;

    always_comb
    begin
        match_next = match_reg;
        if (ctl.step && in_range)
        begin
            match_next = (ctl.first || match_reg) &&
                         (chars_reg[kpos[KIW-1:0]] == key_char);
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        if (ctl.exec_ins && (count == CNTW'(IDX)))
        begin
            chars_reg <= key_buf;
            len_reg   <= kpos;
        end
        else if (ctl.exec_del && shift_out)
        begin
            chars_reg <= nb_chars;
            len_reg   <= nb_len;
        end
    end

endmodule
`default_nettype wire

### rtl/string_set_table.sv
// Channel | Direction | Handshake          | Payload
// s       | in        | s_tvalid, s_tready | s_tdata key_char, s_tuser opcode, s_tlast key_last
// m       | out       | m_tvalid, m_tready | m_tdata was_member, op_status, entry_total
//
// A character that is not the last of its key is taken in the idle state; one cell per entry
// compares its stored character at the key position as it arrives.
// The last character is accepted in the idle state; in the execute state that follows, the cells
// report a hit and the table inserts the key, or on a delete shifts later entries down one cell.
// The execute state waits while the previous result is still held on m.
// Reset empties the set at once; no clearing pass.
`default_nettype none
module string_set_table
    import sst_pkg::*;
#(
    parameter int SET_CAPACITY = 16,
    parameter int WORD_CHARS   = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] key_char
    input  wire logic [1:0] s_tuser,   // [1:0] opcode
    input  wire logic       s_tlast,   // key_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata    // [0] was_member, [2:1] op_status, [7:3] entry_total
);

    localparam int KPW  = $clog2(WORD_CHARS + 1);
    localparam int KIW  = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
    localparam int CNTW = $clog2(SET_CAPACITY + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                              state_reg, state_next;
    logic [KPW-1:0]                    kpos_reg, kpos_next;
    logic                              ovf_reg, ovf_next;
    logic [1:0]                        op_reg, op_next;
    logic [CNTW-1:0]                   count_reg, count_next;
    logic                              m_valid_reg, m_valid_next;
    logic [7:0]                        m_data_reg, m_data_next;
    logic [WORD_CHARS-1:0][CHAR_W-1:0] key_buf_reg;

    logic     s_fire;
    logic     out_free;
    logic     exec_fire;
    logic     member;
    logic     full;
    logic     do_ins;
    logic     do_del;
    logic [1:0] status;
    sst_ctl_t ctl;

    logic [WORD_CHARS-1:0][CHAR_W-1:0] cell_chars [SET_CAPACITY+1];
    logic [KPW-1:0]                    cell_len   [SET_CAPACITY+1];
    logic [SET_CAPACITY-1:0]           hit;
    logic [SET_CAPACITY:0]             shift_c;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;
    assign member    = !ovf_reg && (|hit);
    assign full      = (count_reg == CNTW'(SET_CAPACITY));
    assign do_ins    = exec_fire && !ovf_reg && (op_reg == OP_INSERT) && !member && !full;
    assign do_del    = exec_fire && !ovf_reg && (op_reg == OP_DELETE) && member;

    assign ctl.step     = s_fire;
    assign ctl.first    = (kpos_reg == '0);
    assign ctl.exec_ins = do_ins;
    assign ctl.exec_del = do_del;

    assign shift_c[0]                = 1'b0;
    assign cell_chars[SET_CAPACITY]  = '0;
    assign cell_len[SET_CAPACITY]    = '0;

    for (genvar e = 0; e < SET_CAPACITY; e++)
    begin : g_cell
        sst_cell #(
            .WORD_CHARS (WORD_CHARS),
            .KPW        (KPW),
            .CNTW       (CNTW),
            .IDX        (e)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .key_char  (s_tdata),
            .kpos      (kpos_reg),
            .key_buf   (key_buf_reg),
            .count     (count_reg),
            .nb_chars  (cell_chars[e+1]),
            .nb_len    (cell_len[e+1]),
            .shift_in  (shift_c[e]),
            .chars     (cell_chars[e]),
            .len       (cell_len[e]),
            .hit       (hit[e]),
            .shift_out (shift_c[e+1])
        );
    end

    always_comb
    begin
        status = ST_DONE;
        if (ovf_reg)
        begin
            status = ST_TOO_LONG;
        end
        else if ((op_reg == OP_INSERT) && !member && full)
        begin
            status = ST_FULL;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        kpos_next    = kpos_reg;
        ovf_next     = ovf_reg;
        op_next      = op_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (kpos_reg < KPW'(WORD_CHARS))
                    begin
                        kpos_next = kpos_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        op_next    = s_tuser;
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    if (do_ins)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else if (do_del)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {TOTAL_W'(count_next), status, member};
                    kpos_next    = '0;
                    ovf_next     = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            kpos_reg    <= '0;
            ovf_reg     <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kpos_reg    <= kpos_next;
            ovf_reg     <= ovf_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        m_data_reg <= m_data_next;
        if (s_fire && (kpos_reg < KPW'(WORD_CHARS)))
        begin
            key_buf_reg[kpos_reg[KIW-1:0]] <= s_tdata;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(SET_CAPACITY))
        else $error("entry count above capacity");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> m_valid_reg)
        else $error("operation finished without a result");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(count_reg))
        else $error("entry count changed outside an operation");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && !ovf_reg |-> $onehot0(hit))
        else $error("key found in more than one entry");

    a_long_not_member: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && ovf_reg |=> !m_data_reg[0])
        else $error("overlong key reported as member");

endmodule
`default_nettype wire

### sim/string_set_table_checker.sv
`timescale 1ns / 1ps
module string_set_table_checker
    import sst_pkg::*;
#(
    parameter int SET_CAPACITY = 16,
    parameter int WORD_CHARS   = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] key_char
    input  wire logic [1:0] s_tuser,   // [1:0] opcode
    input  wire logic       s_tlast,   // key_last
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,   // [0] was_member, [2:1] op_status, [7:3] entry_total
    output int              replies_due,
    output int              mismatch_count
);

    typedef struct packed {
        logic [TOTAL_W-1:0] entry_total;
        logic [1:0]         op_status;
        logic               was_member;
    } set_reply_t;

    logic [CHAR_W-1:0] cell_chars [SET_CAPACITY][WORD_CHARS];
    int                cell_len   [SET_CAPACITY];
    int                cell_count = 0;
    logic [CHAR_W-1:0] incoming_chars [WORD_CHARS];
    int                incoming_len = 0;
    bit                incoming_overflow = 1'b0;
    set_reply_t        replies_owed [$];
    int                errors = 0;

    function automatic int find_word();
        int  e;
        int  c;
        bit  same;
        for (e = 0; e < cell_count; e++)
        begin
            if (cell_len[e] == incoming_len)
            begin
                same = 1'b1;
                for (c = 0; c < incoming_len; c++)
                begin
                    if (cell_chars[e][c] != incoming_chars[c])
                        same = 1'b0;
                end
                if (same)
                    return e;
            end
        end
        return -1;
    endfunction

    function automatic bit take_char(input logic [1:0] op, input logic [7:0] ch,
                                     input logic last, output set_reply_t reply);
        int slot;
        int e;
        int c;
        reply = '0;
        if (incoming_len < WORD_CHARS)
        begin
            incoming_chars[incoming_len] = ch;
            incoming_len++;
        end
        else
            incoming_overflow = 1'b1;
        if (!last)
            return 1'b0;
        if (incoming_overflow)
            reply.op_status = ST_TOO_LONG;
        else
        begin
            slot = find_word();
            reply.was_member = (slot >= 0);
            if (op == OP_INSERT && slot < 0)
            begin
                if (cell_count >= SET_CAPACITY)
                    reply.op_status = ST_FULL;
                else
                begin
                    for (c = 0; c < incoming_len; c++)
                        cell_chars[cell_count][c] = incoming_chars[c];
                    cell_len[cell_count] = incoming_len;
                    cell_count++;
                end
            end
            else if (op == OP_DELETE && slot >= 0)
            begin
                // shift later entries down, whole entries
                for (e = slot; e + 1 < cell_count; e++)
                begin
                    for (c = 0; c < WORD_CHARS; c++)
                        cell_chars[e][c] = cell_chars[e + 1][c];
                    cell_len[e] = cell_len[e + 1];
                end
                cell_count--;
            end
        end
        reply.entry_total = TOTAL_W'(cell_count);
        incoming_len      = 0;
        incoming_overflow = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        set_reply_t seen;
        set_reply_t want;
        set_reply_t next_reply;
        if (!rst_n)
        begin
            cell_count        = 0;
            incoming_len      = 0;
            incoming_overflow = 1'b0;
            replies_owed.delete();
            replies_due    <= 0;
            mismatch_count <= errors;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = m_tdata;
                if (replies_owed.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result %h arrived with none outstanding", $time, m_tdata);
                end
                else
                begin
                    want = replies_owed.pop_front();
                    if (seen.was_member !== want.was_member ||
                        seen.op_status !== want.op_status ||
                        seen.entry_total !== want.entry_total)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: member %0b/%0b status %0d/%0d total %0d/%0d (exp/got)",
                                     $time, want.was_member, seen.was_member,
                                     want.op_status, seen.op_status,
                                     want.entry_total, seen.entry_total);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (take_char(s_tuser, s_tdata, s_tlast, next_reply))
                    replies_owed.push_back(next_reply);
            end
            replies_due    <= replies_owed.size();
            mismatch_count <= errors;
        end
    end

endmodule

### sim/string_set_table_tb.sv
`timescale 1ns / 1ps
module string_set_table_tb
    import sst_pkg::*;
();

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int SET_CAPACITY = 16;
    localparam int WORD_CHARS   = 16;
    localparam int KEY_MAX      = 20;
    localparam int WORD_POOL    = 20;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 200;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = '0;   // [7:0] key_char
    logic [1:0] s_tuser  = '0;   // [1:0] opcode
    logic       s_tlast  = 1'b0; // key_last
    logic       m_tready = 1'b0;
    logic       hold_req = 1'b0;
    wire logic       s_tready;
    wire logic       m_tvalid;
    wire logic [7:0] m_tdata;   // [0] was_member, [2:1] op_status, [7:3] entry_total

    int replies_due;
    int mismatch_count;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    int items_sent = 0;

    logic [7:0] pool_chars [WORD_POOL][WORD_CHARS];
    int         pool_len   [WORD_POOL];
    logic [7:0] word_buf   [KEY_MAX];

    string_set_table #(
        .SET_CAPACITY(SET_CAPACITY),
        .WORD_CHARS  (WORD_CHARS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    string_set_table_checker #(
        .SET_CAPACITY(SET_CAPACITY),
        .WORD_CHARS  (WORD_CHARS)
    ) set_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .replies_due   (replies_due),
        .mismatch_count(mismatch_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_char(input logic [1:0] op, input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= op;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // opcode on the inner characters is noise; only the final one selects
    task automatic send_word(input logic [1:0] last_op, input int len);
        int i;
        for (i = 0; i < len; i++)
        begin
            if (i == len - 1)
                send_char(last_op, word_buf[i], 1'b1);
            else
                send_char(2'($urandom_range(3)), word_buf[i], 1'b0);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int         phase;
        int         start;
        int         pick;
        int         len;
        int         w;
        int         i;
        logic [1:0] op;

        for (w = 0; w < WORD_POOL; w++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                pool_len[w] = $urandom_range(3, 1);
            else if (pick < 85)
                pool_len[w] = $urandom_range(WORD_CHARS - 1, 4);
            else
                pool_len[w] = WORD_CHARS;
            for (i = 0; i < WORD_CHARS; i++)
                pool_chars[w][i] = 8'($urandom_range(255));
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the set with single-character keys, then probe it
        for (i = 0; i < SET_CAPACITY; i++)
            send_char(OP_INSERT, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(i), 1'b1);
        send_char(OP_INSERT, 8'h80, 1'b1);
        send_char(OP_INSERT, 8'hFF, 1'b1);
        send_char(OP_QUERY, 8'h80, 1'b1);
        send_char(OP_DELETE, 8'h00, 1'b1);
        send_char(OP_DELETE, 8'h00, 1'b1);
        send_char(OP_SPARE, 8'hFF, 1'b1);
        for (i = 0; i <= WORD_CHARS; i++)
            word_buf[i] = i[0] ? 8'hAA : 8'h55;
        send_word(OP_INSERT, WORD_CHARS + 1);

        for (phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 76; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 76; end
                default: begin idle_pct = 29; stall_pct <= 29; end
            endcase
            if (phase == 0)
            begin
                // long receiver hold-off while the sender keeps pushing
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                begin
                    len = $urandom_range(KEY_MAX, WORD_CHARS + 1);
                    for (i = 0; i < len; i++)
                        word_buf[i] = 8'($urandom_range(255));
                    op = 2'($urandom_range(3));
                end
                else if (pick < 12)
                begin
                    len = $urandom_range(WORD_CHARS, 1);
                    for (i = 0; i < len; i++)
                        word_buf[i] = 8'($urandom_range(255));
                    op = 2'($urandom_range(3));
                end
                else
                begin
                    w   = $urandom_range(WORD_POOL - 1);
                    len = pool_len[w];
                    for (i = 0; i < len; i++)
                        word_buf[i] = pool_chars[w][i];
                    pick = $urandom_range(99);
                    if (pick < 45)
                        op = OP_INSERT;
                    else if (pick < 70)
                        op = OP_DELETE;
                    else if (pick < 95)
                        op = OP_QUERY;
                    else
                        op = OP_SPARE;
                end
                send_word(op, len);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
